// File: src/object_record_parser_assert.svh
// Assertion macros for the object record parser.
`ifndef OBJECT_RECORD_PARSER_ASSERT_SVH
`define OBJECT_RECORD_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ORP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ORP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ORP_ASSERT(lbl, prop, msg)
`define ORP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/orp_pkg.sv
// ----------------------------------------------------------------------------
// orp_pkg
// Types and constants shared by the object record parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package orp_pkg;

  localparam logic [15:0] HDR_CODE  = 16'hCADE;
  localparam logic [15:0] HDR_DATA  = 16'hDADA;
  localparam logic [15:0] HDR_LABEL = 16'hC3B7;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    PH_HDR_HI  = 3'd0,
    PH_HDR_LO  = 3'd1,
    PH_ADR_HI  = 3'd2,
    PH_ADR_LO  = 3'd3,
    PH_CNT_HI  = 3'd4,
    PH_CNT_LO  = 3'd5,
    PH_BODY    = 3'd6,
    PH_WORD_LO = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_LABEL = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr;
    logic [15:0] data;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: src/orp_front.sv
// ----------------------------------------------------------------------------
// orp_front
// Byte parser: assembles big-endian words, decodes headers and forms records.
// ----------------------------------------------------------------------------
`default_nettype none

module orp_front
  import orp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_take,
  input  wire logic [7:0] file_byte,
  output logic            rec_valid,
  output rec_t            rec
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hold_r, hold_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] word;
  logic        final_one;

  assign word      = {hold_r, file_byte};
  assign final_one = (cnt_r == 16'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR_HI;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 8'h00;
      kind_r <= KIND_CODE;
      addr_r <= 16'h0000;
      cnt_r  <= 16'h0000;
    end else begin
      hold_r <= hold_nxt;
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    rec_valid = 1'b0;
    rec.kind  = kind_r;
    rec.addr  = addr_r;
    rec.data  = word;
    rec.last  = final_one;
    if (byte_take) begin
      unique case (phase_r)
        PH_HDR_HI: begin
          hold_nxt  = file_byte;
          phase_nxt = PH_HDR_LO;
        end
        PH_HDR_LO: begin
          phase_nxt = PH_ADR_HI;
          priority if (word == HDR_CODE) begin
            kind_nxt = KIND_CODE;
          end else if (word == HDR_DATA) begin
            kind_nxt = KIND_DATA;
          end else if (word == HDR_LABEL) begin
            kind_nxt = KIND_LABEL;
          end else begin
            phase_nxt = PH_HDR_HI;
          end
        end
        PH_ADR_HI: begin
          hold_nxt  = file_byte;
          phase_nxt = PH_ADR_LO;
        end
        PH_ADR_LO: begin
          addr_nxt  = word;
          phase_nxt = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          hold_nxt  = file_byte;
          phase_nxt = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          cnt_nxt = word;
          if (word != 16'd0) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_HDR_HI;
            if (kind_r == KIND_LABEL) begin
              rec_valid = 1'b1;
              rec.kind  = KIND_EMPTY;
              rec.data  = 16'd0;
              rec.last  = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (kind_r == KIND_LABEL) begin
            cnt_nxt   = cnt_r - 16'd1;
            rec_valid = 1'b1;
            rec.data  = {8'h00, file_byte};
            if (final_one) begin
              phase_nxt = PH_HDR_HI;
            end
          end else begin
            hold_nxt  = file_byte;
            phase_nxt = PH_WORD_LO;
          end
        end
        PH_WORD_LO: begin
          cnt_nxt   = cnt_r - 16'd1;
          addr_nxt  = addr_r + 16'd1;
          rec_valid = 1'b1;
          phase_nxt = final_one ? PH_HDR_HI : PH_BODY;
        end
        default: begin
          phase_nxt = PH_HDR_HI;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/orp_queue.sv
// ----------------------------------------------------------------------------
// orp_queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module orp_queue
  import orp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  rec_t      push_rec,
  input  wire logic pop,
  output rec_t      head_rec,
  output q_stat_t   stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// File: src/orp_back.sv
// ----------------------------------------------------------------------------
// orp_back
// Output stage: pulls records from the queue into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module orp_back
  import orp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  q_stat_t   q_stat,
  input  rec_t      head_rec,
  output logic      pop,
  input  wire logic out_ready,
  output logic      out_valid,
  output rec_t      out_rec
);

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r;

  assign pop           = !q_stat.empty && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_rec       = out_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec_r <= head_rec;
    end
  end

endmodule

`default_nettype wire

// File: src/object_record_parser.sv
// ----------------------------------------------------------------------------
// object_record_parser
// Parses an object file byte stream into code, data and label records.
// ----------------------------------------------------------------------------
// The input channel takes one file byte per cycle on in_valid/in_ready. Bytes
// pair up into big-endian words, label characters apart, and the block accepts
// a new byte in every cycle as long as its internal record queue has room, so
// sustained throughput is one byte per cycle. A byte that completes a code or
// data word, carries a label character or closes an empty label yields one
// result word on the out_ channel; all other bytes only advance the parser.
// A result's record is written into the queue when the byte that caused it is
// accepted; it moves into the output register that drives out_valid once the
// records ahead of it have gone and that register is free or being taken.
// When the receiver holds out_ready low, results collect in
// the queue; once it holds QUEUE_DEPTH records, in_ready drops until the
// output side drains. Reset (rst_n low, synchronous) empties the queue and
// the output register and returns the parser to expecting a header word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "object_record_parser_assert.svh"

module object_record_parser
  import orp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_file_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_record_kind,
  output logic [15:0]      out_target_address,
  output logic [15:0]      out_payload,
  output logic             out_last_of_block
);

  logic    byte_take;
  logic    rec_valid;
  rec_t    rec;
  rec_t    head_rec;
  rec_t    out_rec;
  q_stat_t q_stat;
  logic    pop;
  logic    push;

  assign in_ready  = !q_stat.full;
  assign byte_take = in_valid && in_ready;
  assign push      = rec_valid;

  orp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .file_byte (in_file_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  orp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  orp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign out_record_kind    = out_rec.kind;
  assign out_target_address = out_rec.addr;
  assign out_payload        = out_rec.data;
  assign out_last_of_block  = out_rec.last;

  `ORP_ASSERT(a_no_push_full, push |-> !q_stat.full, "record pushed into full queue")
  `ORP_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty, "record popped from empty queue")
  `ORP_ASSERT(a_push_needs_byte, push |-> byte_take, "record formed without a byte")
  `ORP_ASSERT(a_empty_label_form,
    (out_valid && out_record_kind == KIND_EMPTY) |-> (out_last_of_block && out_payload == 16'd0),
    "empty label result malformed")

endmodule

`default_nettype wire

// File: bench/object_record_checker.sv
// ----------------------------------------------------------------------------
// object_record_checker
// Watches both channels of the object record parser, predicts the result
// words from the accepted file bytes and compares them in order.
// ----------------------------------------------------------------------------
module object_record_checker
  import orp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_record_kind,
  input  logic [15:0] out_target_address,
  input  logic [15:0] out_payload,
  input  logic        out_last_of_block,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      stage;
  logic [7:0]  upper_byte;
  kind_t       block_kind;
  logic [15:0] load_addr;
  logic [15:0] words_left;
  rec_t        expected_records[$];

  initial mismatches = 0;
  initial pending = 0;

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] w;
    w = {upper_byte, b};
    case (stage)
      PH_HDR_HI, PH_ADR_HI, PH_CNT_HI: begin
        upper_byte = b;
        stage = phase_t'(stage + 3'd1);
      end
      PH_HDR_LO: begin
        stage = PH_ADR_HI;
        if (w == HDR_CODE) begin
          block_kind = KIND_CODE;
        end else if (w == HDR_DATA) begin
          block_kind = KIND_DATA;
        end else if (w == HDR_LABEL) begin
          block_kind = KIND_LABEL;
        end else begin
          stage = PH_HDR_HI;
        end
      end
      PH_ADR_LO: begin
        load_addr = w;
        stage = PH_CNT_HI;
      end
      PH_CNT_LO: begin
        words_left = w;
        if (words_left != 16'h0000) begin
          stage = PH_BODY;
        end else begin
          stage = PH_HDR_HI;
          if (block_kind == KIND_LABEL) begin
            expected_records.push_back(rec_t'{KIND_EMPTY, load_addr, 16'h0000, 1'b1});
          end
        end
      end
      PH_BODY: begin
        if (block_kind == KIND_LABEL) begin
          words_left = words_left - 16'd1;
          expected_records.push_back(rec_t'{KIND_LABEL, load_addr, {8'h00, b},
                                            words_left == 16'h0000});
          if (words_left == 16'h0000) stage = PH_HDR_HI;
        end else begin
          upper_byte = b;
          stage = PH_WORD_LO;
        end
      end
      default: begin
        words_left = words_left - 16'd1;
        expected_records.push_back(rec_t'{block_kind, load_addr, w, words_left == 16'h0000});
        load_addr = load_addr + 16'd1;
        stage = (words_left == 16'h0000) ? PH_HDR_HI : PH_BODY;
      end
    endcase
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (!rst_n) begin
      stage = PH_HDR_HI;
      upper_byte = 8'h00;
      block_kind = KIND_CODE;
      load_addr = 16'h0000;
      words_left = 16'h0000;
      expected_records.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_file_byte);
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          $error("unexpected result word: kind %0d address %h payload %h last %b",
                 out_record_kind, out_target_address, out_payload, out_last_of_block);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          if (out_record_kind !== want.kind) begin
            $error("record_kind: expected %0d, got %0d", want.kind, out_record_kind);
            mismatches++;
          end
          if (out_target_address !== want.addr) begin
            $error("target_address: expected %h, got %h", want.addr, out_target_address);
            mismatches++;
          end
          if (out_payload !== want.data) begin
            $error("payload: expected %h, got %h", want.data, out_payload);
            mismatches++;
          end
          if (out_last_of_block !== want.last) begin
            $error("last_of_block: expected %b, got %b", want.last, out_last_of_block);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_records.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the object record parser. Feeds a directed byte stream and
// then random code, data and label records mixed with unknown headers and
// stray bytes, under several sender and receiver idling patterns, including
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import orp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS    = 1350;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_record_kind;
  logic [15:0] out_target_address;
  logic [15:0] out_payload;
  logic        out_last_of_block;
  int          mismatches;
  int          pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off_req = 1'b0;
  int          idle_cycles = 0;
  int          record_bytes = 0;

  always #5 clk = ~clk;

  object_record_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_file_byte      (in_file_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_target_address(out_target_address),
    .out_payload       (out_payload),
    .out_last_of_block (out_last_of_block)
  );

  object_record_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_file_byte      (in_file_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_target_address(out_target_address),
    .out_payload       (out_payload),
    .out_last_of_block (out_last_of_block),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  initial begin
    bit hold_off_done;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("object_record_parser verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_file_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic push_word(input logic [15:0] w);
    push_byte(w[15:8]);
    push_byte(w[7:0]);
  endtask

  task automatic push_record();
    int unsigned pick;
    int unsigned count;
    logic [15:0] header;
    logic [15:0] base;
    logic [15:0] junk;
    pick = $urandom_range(39);
    if (pick < 36) begin
      header = (pick < 12) ? HDR_CODE : (pick < 24) ? HDR_DATA : HDR_LABEL;
      base = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(3)) : 16'($urandom);
      count = ($urandom_range(9) == 0) ? $urandom_range(24, 6) : $urandom_range(5);
      push_word(header);
      push_word(base);
      push_word(16'(count));
      repeat ((header == HDR_LABEL) ? count : 2 * count) push_byte(8'($urandom));
      record_bytes += 6 + ((header == HDR_LABEL) ? count : 2 * count);
    end else if (pick < 39) begin
      do junk = 16'($urandom); while (junk inside {HDR_CODE, HDR_DATA, HDR_LABEL});
      push_word(junk);
    end else begin
      push_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned send_pcts[4];
    int unsigned stall_pcts[4];
    send_pcts = '{0, 51, 0, 21};
    stall_pcts = '{0, 0, 51, 21};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_word(16'h1234);
    push_word(HDR_CODE);
    push_word(16'hFFFF);
    push_word(16'h0002);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(HDR_LABEL);
    push_word(16'hABCD);
    push_word(16'h0000);
    push_word(HDR_LABEL);
    push_word(16'h8001);
    push_word(16'h0001);
    push_byte(8'h41);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      while (record_bytes < (p + 1) * RANDOM_ITEMS / 4) begin
        if (p == 0 && record_bytes >= 150 && !hold_off_req) begin
          hold_off_req <= 1'b1;
        end
        push_record();
      end
    end

    push_word(HDR_CODE);
    push_byte(8'h00);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("object_record_parser verification clean");
    end else begin
      $display("object_record_parser verification failed");
    end
    $finish;
  end

endmodule
